// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mat4mul_pkg.sv =====
// ----------------------------------------------------------------------------
// mat4mul_pkg
// Types and constants shared by the matrix multiplier modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mat4mul_pkg;

    localparam int IDX_W   = 4;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int TDATA_W = 40;   // index + value, padded to whole bytes

    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL   = 2'd2;

    // tag travelling with each product term down the MAC pipeline
    typedef struct packed {
        logic             first;   // k == 0, restart accumulation
        logic             lastk;   // k == DIM-1, element complete
        logic             last;    // final element of the product
        logic [IDX_W-1:0] idx;     // row*DIM+col, kept to IDX_W bits
    } tag_t;

endpackage

`default_nettype wire

// ===== src/mat4mul_store.sv =====
// ----------------------------------------------------------------------------
// mat4mul_store
// Matrix element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mat4mul_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  waddr,
    input  wire logic [mat4mul_pkg::VAL_W-1:0]  wdata,
    input  wire logic                           re,
    input  wire logic [AW-1:0]                  raddr,
    output logic      [mat4mul_pkg::VAL_W-1:0]  rdata
);
    import mat4mul_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0] rdata_reg;

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/mat4mul_seq.sv =====
// ----------------------------------------------------------------------------
// mat4mul_seq
// Address sequencer: walks row, col, k and issues one read pair per step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mat4mul_seq #(
    parameter int DIM = 4,
    parameter int AW  = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic               adv,
    output logic                    idle,
    output logic                    issue_valid,
    output mat4mul_pkg::tag_t       issue_tag,
    output logic [AW-1:0]           l_addr,
    output logic [AW-1:0]           r_addr
);
    import mat4mul_pkg::*;

    localparam int CW = $clog2(DIM);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_ISSUE = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   row_reg, row_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [CW-1:0]   k_reg, k_next;
    logic            k_end, col_end, row_end;

    assign k_end   = (k_reg == CW'(DIM - 1));
    assign col_end = (col_reg == CW'(DIM - 1));
    assign row_end = (row_reg == CW'(DIM - 1));

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_ISSUE;
                    row_next   = '0;
                    col_next   = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE: begin
                if (adv) begin
                    k_next = k_end ? '0 : k_reg + 1'b1;
                    if (k_end) begin
                        col_next = col_end ? '0 : col_reg + 1'b1;
                        if (col_end) begin
                            row_next = row_end ? '0 : row_reg + 1'b1;
                            if (row_end) begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
        end
    end

    assign idle        = (state_reg == ST_IDLE);
    assign issue_valid = (state_reg == ST_ISSUE);

    // L[row][k] and R[k][col]
    assign l_addr = AW'(int'(row_reg) * DIM + int'(k_reg));
    assign r_addr = AW'(int'(k_reg) * DIM + int'(col_reg));

    always_comb begin
        issue_tag.first = (k_reg == '0);
        issue_tag.lastk = k_end;
        issue_tag.last  = row_end && col_end;
        issue_tag.idx   = IDX_W'(int'(row_reg) * DIM + int'(col_reg));
    end

    `CHK_NEXT(a_seq_done, aclk, aresetn,
        (state_reg == ST_ISSUE) && adv && k_end && col_end && row_end,
        state_reg == ST_IDLE, "sequencer did not stop after final step")

endmodule

`default_nettype wire

// ===== src/mat4mul_mac.sv =====
// ----------------------------------------------------------------------------
// mat4mul_mac
// Multiply-accumulate pipeline with floor shift, saturation and output word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mat4mul_mac #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           issue_valid,
    input  wire mat4mul_pkg::tag_t              issue_tag,
    input  wire logic [mat4mul_pkg::VAL_W-1:0]  l_data,
    input  wire logic [mat4mul_pkg::VAL_W-1:0]  r_data,
    output logic                                adv,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output mat4mul_pkg::tag_t                   out_tag,
    output logic [mat4mul_pkg::VAL_W-1:0]       out_value,
    output logic                                out_ovf
);
    import mat4mul_pkg::*;

    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(DIM);

    // stage 1: read data from stores, tag alongside
    logic                     s1_valid_reg;
    tag_t                     s1_tag_reg;
    // stage 2: product
    logic                     s2_valid_reg;
    tag_t                     s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    // stage 3: complete sum
    logic                     s3_valid_reg;
    tag_t                     s3_tag_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    // output word
    logic                     out_valid_reg;
    tag_t                     out_tag_reg;
    logic [VAL_W-1:0]         out_value_reg, sat_value;
    logic                     out_ovf_reg, sat_ovf;

    logic signed [ACC_W-1:0]  shifted;
    logic [ACC_W-VAL_W:0]     hi_bits;

    // whole pipeline moves together, stalls while the output word waits
    assign adv = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= issue_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_tag_reg.lastk;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_comb begin
        acc_next = (s2_tag_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= $signed(l_data) * $signed(r_data);
            s3_tag_reg <= s2_tag_reg;
            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            if (s3_valid_reg) begin
                out_tag_reg   <= s3_tag_reg;
                out_value_reg <= sat_value;
                out_ovf_reg   <= sat_ovf;
            end
        end
    end

    // floor by arithmetic shift, then clamp to 32 bits signed
    assign shifted = acc_reg >>> FRAC_BITS;
    assign hi_bits = shifted[ACC_W-1:VAL_W-1];

    always_comb begin
        sat_ovf   = 1'b0;
        sat_value = shifted[VAL_W-1:0];
        if (!shifted[ACC_W-1] && (|hi_bits)) begin
            sat_ovf   = 1'b1;
            sat_value = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (shifted[ACC_W-1] && !(&hi_bits)) begin
            sat_ovf   = 1'b1;
            sat_value = {1'b1, {(VAL_W-1){1'b0}}};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_value = out_value_reg;
    assign out_ovf   = out_ovf_reg;

    `CHK_NEXT(a_mac_hold, aclk, aresetn, !adv,
        $stable(acc_reg) && $stable(prod_reg), "pipeline moved during a stall")

endmodule

`default_nettype wire

// ===== src/matrix4x4_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Fixed-point DIM x DIM matrix multiplier, signed Q16.16, row-major.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the mode. Mode 0 writes one element of
//   the left matrix, mode 1 one of the right matrix, at row*DIM+col; such
//   words give no output. Mode 2 starts a multiply; mode 3 is accepted and
//   dropped. Out-of-range write indices are dropped.
//   Output stream (m_*): DIM*DIM product words in row-major order, tlast on
//   the final one, tuser set where the element saturated.
//   Issue: a multiply holds the input while it issues, one product term per
//   cycle unless the output stalls, through the single 32x32 multiplier fed
//   by one read port on each matrix store.
//   Reset: both matrices read as zero until written; no clearing pass.
//   Back-pressure: while m_tready is low with a word waiting, the whole
//   pipeline and sequencer freeze; nothing is dropped. Loads are taken
//   whenever no multiply is issuing, including while results drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module matrix4x4_multiply #(
    parameter int DIM       = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mat4mul_pkg::TDATA_W-1:0]   s_tdata,  // elem_index[3:0], elem_value[35:4]
    input  wire logic [mat4mul_pkg::MODE_W-1:0]    s_tuser,  // mode[1:0]
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mat4mul_pkg::TDATA_W-1:0]        m_tdata,  // out_index[3:0], out_value[35:4]
    output logic [0:0]                             m_tuser,  // overflow[0]
    output logic                                   m_tlast
);
    import mat4mul_pkg::*;

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);

    logic              s_accept;
    logic [IDX_W-1:0]  in_idx;
    logic [VAL_W-1:0]  in_val;
    logic              idx_ok;
    logic              l_we, r_we, start;

    logic              adv, idle, issue_valid;
    tag_t              issue_tag, out_tag;
    logic [AW-1:0]     l_addr, r_addr;
    logic [VAL_W-1:0]  l_data, r_data, out_value;
    logic              out_valid, out_ovf;

    // input word decode
    assign s_tready = idle;
    assign s_accept = s_tvalid && s_tready;
    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_val   = s_tdata[IDX_W +: VAL_W];
    assign idx_ok   = (int'(in_idx) < CELLS);
    assign l_we     = s_accept && (s_tuser == MODE_LEFT) && idx_ok;
    assign r_we     = s_accept && (s_tuser == MODE_RIGHT) && idx_ok;
    assign start    = s_accept && (s_tuser == MODE_MUL);

    mat4mul_store #(.DEPTH(CELLS), .AW(AW)) u_left (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (l_we),
        .waddr   (AW'(in_idx)),
        .wdata   (in_val),
        .re      (adv),
        .raddr   (l_addr),
        .rdata   (l_data)
    );

    mat4mul_store #(.DEPTH(CELLS), .AW(AW)) u_right (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (r_we),
        .waddr   (AW'(in_idx)),
        .wdata   (in_val),
        .re      (adv),
        .raddr   (r_addr),
        .rdata   (r_data)
    );

    mat4mul_seq #(.DIM(DIM), .AW(AW)) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .adv         (adv),
        .idle        (idle),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .l_addr      (l_addr),
        .r_addr      (r_addr)
    );

    mat4mul_mac #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .issue_tag   (issue_tag),
        .l_data      (l_data),
        .r_data      (r_data),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (m_tready),
        .out_tag     (out_tag),
        .out_value   (out_value),
        .out_ovf     (out_ovf)
    );

    // result word packing
    assign m_tvalid = out_valid;
    assign m_tdata  = {{(TDATA_W - IDX_W - VAL_W){1'b0}}, out_value, out_tag.idx};
    assign m_tuser  = out_ovf;
    assign m_tlast  = out_tag.last;

    `CHK_SAME(a_last_index, aclk, aresetn, m_tvalid && m_tlast,
        m_tdata[IDX_W-1:0] == IDX_W'(CELLS - 1), "tlast on wrong element")

    `CHK_SAME(a_ovf_clamped, aclk, aresetn, m_tvalid && m_tuser[0],
        (m_tdata[IDX_W +: VAL_W] == 32'h7FFFFFFF) || (m_tdata[IDX_W +: VAL_W] == 32'h80000000),
        "overflow flag without clamped value")

endmodule

`default_nettype wire

// ===== sim/matrix4x4_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// matrix4x4_multiply_tb
// Self-checking bench for the Q16.16 4x4 matrix multiplier. Load words fill
// the left and right stores and multiply words release sixteen product words.
// An in-bench model predicts every product word. A checker compares each
// accepted output word, field by field, against the oldest prediction. Both
// stream sides idle at random. One long output stall backs up the input. The
// final stretch runs with no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix4x4_multiply_tb;

    import mat4mul_pkg::*;

    localparam int DIM         = 4;
    localparam int FRAC_BITS   = 16;
    localparam int CELLS       = DIM * DIM;
    localparam int QUIET_LIMIT = 4000;   // cycles with no word moving on either side
    localparam int LONG_HOLD   = 300;    // output stall long enough to back up the input

    // mode 3 has no meaning and the block drops it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
    localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             ovf;
        logic             last;
    } prod_word_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;    // elem_index[3:0], elem_value[35:4], zero pad
    logic [MODE_W-1:0]   s_tuser;    // mode[1:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;    // out_index[3:0], out_value[35:4]
    logic [0:0]          m_tuser;    // overflow[0]
    logic                m_tlast;

    // model copy of the two stores
    logic signed [VAL_W-1:0] lhs_store [CELLS];
    logic signed [VAL_W-1:0] rhs_store [CELLS];

    prod_word_t expected_products [$];

    int  mismatches        = 0;
    int  words_sent        = 0;   // load and multiply words, noise not counted
    int  quiet_cycles      = 0;
    int  long_hold_cycles  = 0;
    bit  hold_active       = 1'b0;
    bit  idling_on         = 1'b1;

    matrix4x4_multiply i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Exact 66-bit dot product, floor shift, then clamp to 32 bits.
    function automatic void queue_product();
        logic signed [65:0] acc;
        logic signed [65:0] a;
        logic signed [65:0] b;
        logic signed [49:0] q;
        prod_word_t         w;
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                acc = '0;
                for (int k = 0; k < DIM; k++) begin
                    a   = lhs_store[r*DIM + k];
                    b   = rhs_store[k*DIM + c];
                    acc = acc + a * b;
                end
                q       = acc >>> FRAC_BITS;
                w.idx   = IDX_W'(r*DIM + c);
                w.ovf   = 1'b0;
                w.last  = (r*DIM + c == CELLS - 1);
                if (q > SAT_HI) begin
                    w.value = 32'h7fff_ffff;
                    w.ovf   = 1'b1;
                end else if (q < SAT_LO) begin
                    w.value = 32'h8000_0000;
                    w.ovf   = 1'b1;
                end else begin
                    w.value = q[VAL_W-1:0];
                end
                expected_products.push_back(w);
            end
        end
    endfunction

    function automatic void apply_word(input logic [MODE_W-1:0] op,
                                       input logic [IDX_W-1:0]  pos,
                                       input logic [VAL_W-1:0]  value);
        case (op)
            MODE_LEFT:  lhs_store[pos] = value;
            MODE_RIGHT: rhs_store[pos] = value;
            MODE_MUL:   queue_product();
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: mismatch at %0t ns: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Output checker and watchdog
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin : check_products
        prod_word_t want;
        prod_word_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[IDX_W-1:0], m_tdata[IDX_W +: VAL_W], m_tuser[0], m_tlast};
            if (expected_products.size() == 0) begin
                report_mismatch($sformatf("unexpected word idx %0d val %h ovf %b last %b",
                                          got.idx, got.value, got.ovf, got.last));
            end else begin
                want = expected_products.pop_front();
                if (got.idx !== want.idx || got.value !== want.value ||
                    got.ovf !== want.ovf || got.last !== want.last)
                    report_mismatch($sformatf(
                        "want idx %0d val %h ovf %b last %b, got idx %0d val %h ovf %b last %b",
                        want.idx, want.value, want.ovf, want.last,
                        got.idx, got.value, got.ovf, got.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random ready bursts, plus one long stall on request
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int n;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (long_hold_cycles != 0) begin
                m_tready        <= 1'b0;
                n                = long_hold_cycles;
                long_hold_cycles = 0;
                hold_active      = 1'b1;
                repeat (n) @(posedge aclk);
                hold_active      = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one word and returns at the edge that takes it. tvalid stays
    // high on return unless an idle burst followed, so callers must not let
    // time pass without lowering it.
    task automatic send_word(input logic [MODE_W-1:0] op,
                             input logic [IDX_W-1:0]  pos,
                             input logic [VAL_W-1:0]  value);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(TDATA_W-IDX_W-VAL_W){1'b0}}, value, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_word(op, pos, value);
        if (op != MODE_UNUSED)
            words_sent++;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic send_multiply();
        send_word(MODE_MUL, IDX_W'($urandom()), $urandom());
    endtask

    // sender pause until every predicted word has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(posedge aclk);
    endtask

    // spread over small, mid-range, unit and extreme Q16.16 values
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3, 4, 5: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            6:       return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            7:       return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic load_random_elem();
        send_word($urandom_range(0, 1) ? MODE_RIGHT : MODE_LEFT,
                  IDX_W'($urandom_range(0, CELLS - 1)), pick_value());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // both stores read as zero straight after reset
    task automatic test_reset_state();
        send_multiply();
    endtask

    // a large positive and the most negative product clamp and flag
    task automatic test_saturation();
        send_word(MODE_LEFT,  4'd0, 32'h7fff_ffff);
        send_word(MODE_RIGHT, 4'd0, 32'h7fff_ffff);
        send_word(MODE_LEFT,  4'd1, 32'h8000_0000);
        send_word(MODE_RIGHT, 4'd5, 32'h7fff_ffff);
        send_multiply();
    endtask

    // mode 3 must leave both stores alone and give no output
    task automatic test_unused_mode();
        send_word(MODE_UNUSED, 4'd0,  32'h0000_0000);
        send_word(MODE_UNUSED, 4'd15, 32'hffff_ffff);
        send_multiply();
    endtask

    // shift rounds toward minus infinity: -1 ulp times +1 ulp floors to -1 ulp
    task automatic test_floor_rounding();
        send_word(MODE_LEFT,  4'd15, 32'hffff_ffff);
        send_word(MODE_RIGHT, 4'd15, 32'h0000_0001);
        send_word(MODE_LEFT,  4'd10, 32'h0000_0001);
        send_word(MODE_RIGHT, 4'd10, 32'h0000_0001);
        send_word(MODE_LEFT,  4'd5,  32'h0001_8000);
        send_word(MODE_RIGHT, 4'd6,  32'hfffe_8000);
        send_multiply();
    endtask

    // four 2^62 products: the sum needs more than 64 bits
    task automatic test_wide_sum();
        for (int k = 0; k < DIM; k++) begin
            send_word(MODE_LEFT,  IDX_W'(3*DIM + k), 32'h8000_0000);
            send_word(MODE_RIGHT, IDX_W'(k*DIM + 3), 32'h8000_0000);
        end
        send_multiply();
        wait_drained();
    endtask

    // long output stall with the sender still offering: input must back up
    task automatic test_output_stall();
        s_tvalid <= 1'b0;
        long_hold_cycles = LONG_HOLD;
        wait (hold_active);
        send_multiply();
        repeat (4) load_random_elem();
        send_multiply();
        repeat (4) load_random_elem();
        send_multiply();
    endtask

    // whole-matrix loads, sparse updates, noise and back-to-back multiplies
    task automatic test_random_products(input int target);
        int kind;
        while (words_sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 3) begin
                for (int p = 0; p < CELLS; p++)
                    send_word(MODE_LEFT, IDX_W'(p), pick_value());
                for (int p = 0; p < CELLS; p++)
                    send_word(MODE_RIGHT, IDX_W'(p), pick_value());
            end else if (kind == 3) begin
                for (int p = 0; p < CELLS; p++)
                    send_word($urandom_range(0, 1) ? MODE_RIGHT : MODE_LEFT,
                              IDX_W'(p), pick_value());
            end else if (kind < 9) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 7) == 0)
                        send_word(MODE_UNUSED, IDX_W'($urandom()), $urandom());
                    load_random_elem();
                end
            end else begin
                wait_drained();
            end
            send_multiply();
            if ($urandom_range(0, 5) == 0)
                send_multiply();
        end
    endtask

    initial begin : run_tests
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_LEFT;
        aresetn  <= 1'b0;
        // model stores start cleared, as the block's stores do after reset
        foreach (lhs_store[i]) begin
            lhs_store[i] = '0;
            rhs_store[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_saturation();
        test_unused_mode();
        test_floor_rounding();
        test_wide_sum();
        test_output_stall();
        test_random_products(370);

        // last stretch with no random idling on either side
        idling_on = 1'b0;
        test_random_products(words_sent + 60);

        wait_drained();
        repeat (DIM*DIM*DIM + 8) @(posedge aclk);
        if (expected_products.size() != 0)
            report_mismatch($sformatf("%0d product words never came",
                                      expected_products.size()));
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/mat4mul_pkg.sv
src/mat4mul_store.sv
src/mat4mul_seq.sv
src/mat4mul_mac.sv
src/matrix4x4_multiply.sv
sim/matrix4x4_multiply_tb.sv
